// ===== rtl/core/swm_pkg.sv =====
`default_nettype none

package swm_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int MAX_HALF_DEFAULT = 15;
   localparam int HALF_BITS = 4;
   localparam logic [HALF_BITS-1:0] HALF_RESET = 4'd1;

   typedef struct packed {
      logic cur_valid;
      logic evicting;
      logic rem_valid;
      logic ev_at;
      logic ev_below;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/core/swm_cell.sv =====
`default_nettype none

module swm_cell #(
   parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEFAULT,
   parameter int AGE_W = 5
) (
   input  wire logic                   clock,
   input  wire logic                   shift_en,
   input  wire logic [SAMPLE_BITS-1:0] sample,
   input  wire logic [AGE_W-1:0]       last_age,
   input  wire swm_pkg::cell_ctrl_type ctrl,
   input  wire logic [SAMPLE_BITS-1:0] low_value,
   input  wire logic [AGE_W-1:0]       low_age,
   input  wire logic                   low_cond,
   input  wire logic [SAMPLE_BITS-1:0] up_value,
   input  wire logic [AGE_W-1:0]       up_age,
   output logic                        cond,
   output logic                        hit,
   output logic [SAMPLE_BITS-1:0]      value,
   output logic [AGE_W-1:0]            age
);

   logic [SAMPLE_BITS-1:0] value_ff;
   logic [SAMPLE_BITS-1:0] value_in;
   logic [AGE_W-1:0]       age_ff;
   logic [AGE_W-1:0]       age_in;
   logic [SAMPLE_BITS-1:0] own_sh_value;
   logic [AGE_W-1:0]       own_sh_age;
   logic [SAMPLE_BITS-1:0] low_sh_value;
   logic [AGE_W-1:0]       low_sh_age;
   logic                   at_slot;

   // The evicted entry closes its gap; the new sample opens one after all values not above it.
   always_comb begin
      own_sh_value = ctrl.ev_at ? up_value : value_ff;
      own_sh_age   = ctrl.ev_at ? up_age : age_ff;
      low_sh_value = ctrl.ev_below ? value_ff : low_value;
      low_sh_age   = ctrl.ev_below ? age_ff : low_age;
      cond         = ctrl.rem_valid && (own_sh_value <= sample);
      at_slot      = !cond && low_cond;
      hit          = ctrl.cur_valid && ctrl.evicting && (age_ff == last_age);
      if (cond) begin
         value_in = own_sh_value;
         age_in   = own_sh_age + AGE_W'(1);
      end else if (at_slot) begin
         value_in = sample;
         age_in   = '0;
      end else begin
         value_in = low_sh_value;
         age_in   = low_sh_age + AGE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

   assign value = value_ff;
   assign age   = age_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sliding_window_median.sv =====
// Sliding-window median of an unsigned sample stream.
// Requests arrive on the req_ channel (valid/stall): each carries one sample and a start
// flag that empties the window before the sample enters. The window holds the newest
// 2h+1 samples, with h written through csr_write_en/csr_write_data; the user must write h
// only while the block is idle, which the block itself does not enforce. Writing a
// different h empties the window. Once the window is full, every request yields one
// median on the rsp_ channel; earlier requests yield nothing. The window is a row of
// sorted cells; each request inserts its sample and evicts the oldest in a single update,
// so one request is taken per cycle while req_stall is low. The median is read from the
// middle cell after the row has been updated and is registered with rsp_valid.
// While the receiver stalls, one median waits in the output register and the next can
// wait behind it; req_stall rises only when both are occupied.
// Synchronous reset empties the window, drops pending medians and sets h to 1.
`default_nettype none

module sliding_window_median #(
   parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEFAULT,
   parameter int MAX_HALF = swm_pkg::MAX_HALF_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_en,
   input  wire logic [swm_pkg::HALF_BITS-1:0] csr_write_data,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [SAMPLE_BITS-1:0]        req_sample_value,
   input  wire logic                          req_start_sequence,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [SAMPLE_BITS-1:0]             rsp_median_value
);

   localparam int DEPTH = 2 * MAX_HALF + 1;
   localparam int AGE_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int HALF_W = $clog2(MAX_HALF + 1);

   logic [swm_pkg::HALF_BITS-1:0] half_ff;
   logic [CNT_W-1:0]              fill_ff;
   logic                          pend_ff;
   logic                          rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]        median_ff;

   logic [HALF_W-1:0]      half_eff;
   logic [AGE_W-1:0]       last_age;
   logic [AGE_W-1:0]       mid_idx;
   logic [CNT_W-1:0]       win_len;
   logic [CNT_W-1:0]       fill_eff;
   logic [CNT_W-1:0]       fill_rem;
   logic [CNT_W-1:0]       fill_next;
   logic                   full;
   logic                   emit;
   logic                   accept;
   logic                   move;

   logic [DEPTH-1:0]       hit_vec;
   logic [DEPTH-1:0]       ev_at;
   logic [DEPTH-1:0]       cond_vec;
   logic [SAMPLE_BITS-1:0] cell_value [DEPTH];
   logic [AGE_W-1:0]       cell_age [DEPTH];

   always_comb begin
      if (32'(half_ff) > MAX_HALF) begin
         half_eff = HALF_W'(MAX_HALF);
      end else begin
         half_eff = HALF_W'(half_ff);
      end
      last_age  = AGE_W'({half_eff, 1'b0});
      mid_idx   = AGE_W'(half_eff);
      win_len   = CNT_W'({half_eff, 1'b1});
      fill_eff  = req_start_sequence ? '0 : fill_ff;
      full      = (fill_eff == win_len);
      fill_rem  = fill_eff - CNT_W'(full);
      fill_next = full ? win_len : fill_eff + CNT_W'(1);
      emit      = (fill_next == win_len);
      move      = pend_ff && (!rsp_valid_ff || !rsp_stall);
      req_stall = pend_ff && rsp_valid_ff && rsp_stall;
      accept    = req_valid && !req_stall;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      swm_pkg::cell_ctrl_type ctrl;
      logic [SAMPLE_BITS-1:0] low_value;
      logic [AGE_W-1:0]       low_age;
      logic                   low_cond;
      logic [SAMPLE_BITS-1:0] up_value;
      logic [AGE_W-1:0]       up_age;

      assign ev_at[i] = |hit_vec[i:0];

      if (i == 0) begin : g_low_edge
         assign low_value     = '0;
         assign low_age       = '0;
         assign low_cond      = 1'b1;
         assign ctrl.ev_below = 1'b0;
      end else begin : g_low
         assign low_value     = cell_value[i-1];
         assign low_age       = cell_age[i-1];
         assign low_cond      = cond_vec[i-1];
         assign ctrl.ev_below = ev_at[i-1];
      end

      if (i == DEPTH - 1) begin : g_up_edge
         assign up_value = '0;
         assign up_age   = '0;
      end else begin : g_up
         assign up_value = cell_value[i+1];
         assign up_age   = cell_age[i+1];
      end

      assign ctrl.cur_valid = CNT_W'(i) < fill_eff;
      assign ctrl.evicting  = full;
      assign ctrl.rem_valid = CNT_W'(i) < fill_rem;
      assign ctrl.ev_at     = ev_at[i];

      swm_cell #(
         .SAMPLE_BITS(SAMPLE_BITS),
         .AGE_W(AGE_W)
      ) u_cell (
         .clock(clock),
         .shift_en(accept),
         .sample(req_sample_value),
         .last_age(last_age),
         .ctrl(ctrl),
         .low_value(low_value),
         .low_age(low_age),
         .low_cond(low_cond),
         .up_value(up_value),
         .up_age(up_age),
         .cond(cond_vec[i]),
         .hit(hit_vec[i]),
         .value(cell_value[i]),
         .age(cell_age[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff      <= swm_pkg::HALF_RESET;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            fill_ff <= fill_next;
            pend_ff <= emit;
         end else if (move) begin
            pend_ff <= 1'b0;
         end
         if (csr_write_en) begin
            if (csr_write_data != half_ff) begin
               fill_ff <= '0;
            end
            half_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         median_ff <= cell_value[mid_idx];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_value = median_ff;

endmodule

`default_nettype wire

// ===== verif/swm_median_checker.sv =====
`default_nettype none

module swm_median_checker #(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_HALF = 15
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_en,
   input  wire logic [swm_pkg::HALF_BITS-1:0] csr_write_data,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic [SAMPLE_BITS-1:0]        req_sample_value,
   input  wire logic                          req_start_sequence,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [SAMPLE_BITS-1:0]        rsp_median_value,
   output int                                 medians_pending,
   output int                                 medians_checked,
   output int                                 failures
);

   localparam int PRINT_CAP = 20;

   logic [SAMPLE_BITS-1:0]        window_q[$];
   logic [SAMPLE_BITS-1:0]        medians_due[$];
   logic [swm_pkg::HALF_BITS-1:0] half_setting;
   logic [SAMPLE_BITS-1:0]        due_median;
   int                            fail_tally;
   int                            checked_tally;

   initial begin
      medians_pending = 0;
      medians_checked = 0;
      failures = 0;
      fail_tally = 0;
      checked_tally = 0;
      half_setting = swm_pkg::HALF_RESET;
   end

   task automatic report_mismatch(input string what, input logic [SAMPLE_BITS-1:0] got,
                                  input logic [SAMPLE_BITS-1:0] want);
      if (fail_tally < PRINT_CAP) begin
         $display("mismatch at median %0d: %s (got %h, expected %h)",
                  checked_tally, what, got, want);
      end
      fail_tally++;
   endtask

   function automatic logic [SAMPLE_BITS-1:0] rank_in_window(input int rank);
      logic [SAMPLE_BITS-1:0] sorted[$];
      logic [SAMPLE_BITS-1:0] v;
      int                     j;
      sorted = window_q;
      for (int i = 1; i < sorted.size(); i++) begin
         v = sorted[i];
         j = i - 1;
         while (j >= 0 && sorted[j] > v) begin
            sorted[j + 1] = sorted[j];
            j--;
         end
         sorted[j + 1] = v;
      end
      return sorted[rank];
   endfunction

   task automatic take_sample(input logic [SAMPLE_BITS-1:0] value, input logic start);
      int half;
      int span;
      half = (half_setting > MAX_HALF) ? MAX_HALF : int'(half_setting);
      span = 2 * half + 1;
      if (start) begin
         window_q.delete();
      end
      window_q.push_back(value);
      while (window_q.size() > span) begin
         void'(window_q.pop_front());
      end
      if (window_q.size() == span) begin
         medians_due.push_back(rank_in_window(half));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         window_q.delete();
         medians_due.delete();
         half_setting = swm_pkg::HALF_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (medians_due.size() == 0) begin
               report_mismatch("median with no request waiting", rsp_median_value, '0);
            end else begin
               due_median = medians_due.pop_front();
               if (rsp_median_value !== due_median) begin
                  report_mismatch("median_value", rsp_median_value, due_median);
               end
            end
            checked_tally++;
         end
         if (csr_write_en) begin
            // A new half-width empties the window; rewriting the same one keeps it.
            if (csr_write_data != half_setting) begin
               window_q.delete();
            end
            half_setting = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            take_sample(req_sample_value, req_start_sequence);
         end
      end
      medians_pending <= medians_due.size();
      medians_checked <= checked_tally;
      failures <= fail_tally;
   end

endmodule

`default_nettype wire

// ===== verif/sliding_window_median_tb.sv =====
`default_nettype none

module sliding_window_median_tb;

   localparam int SAMPLE_BITS = 16;
   localparam int MAX_HALF = 15;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int SEGMENT_COUNT = 10;
   localparam int SEGMENT_ITEMS = 53;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_write_en = 1'b0;
   logic [swm_pkg::HALF_BITS-1:0]   csr_write_data = '0;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [SAMPLE_BITS-1:0]          req_sample_value = '0;
   logic                            req_start_sequence = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [SAMPLE_BITS-1:0]          rsp_median_value;

   int medians_pending;
   int medians_checked;
   int failures;
   int req_idle_pct = 19;
   int rsp_stall_pct = 67;
   int quiet_cycles = 0;
   int requests_sent = 0;
   int half_writes = 0;

   logic [swm_pkg::HALF_BITS-1:0] segment_halves[SEGMENT_COUNT] =
      '{15, 2, 7, 7, 1, 0, 15, 4, 9, 3};
   logic [SAMPLE_BITS-1:0] directed_values[17] = '{
      16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF,
      16'h0005, 16'h0005, 16'h0005, 16'h0005, 16'h0006, 16'h0004, 16'h0004,
      16'h0009, 16'h0001, 16'h0001};
   logic                   directed_starts[17] = '{
      0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0, 0, 1, 1};

   sliding_window_median #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .MAX_HALF(MAX_HALF)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample_value(req_sample_value),
      .req_start_sequence(req_start_sequence),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_median_value(rsp_median_value)
   );

   swm_median_checker #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .MAX_HALF(MAX_HALF)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample_value(req_sample_value),
      .req_start_sequence(req_start_sequence),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_median_value(rsp_median_value),
      .medians_pending(medians_pending),
      .medians_checked(medians_checked),
      .failures(failures)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= (rsp_stall_pct > 0) && ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en)
      begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2, 3: return SAMPLE_BITS'($urandom_range(7));
         4: return SAMPLE_BITS'($urandom_range(16'hFFFF, 16'hFFF0));
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic send_sample(input logic [SAMPLE_BITS-1:0] value, input logic start);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_value <= value;
      req_start_sequence <= start;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      requests_sent++;
   endtask

   task automatic wait_for_medians();
      req_valid <= 1'b0;
      @(posedge clock);
      while (medians_pending != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_half(input logic [swm_pkg::HALF_BITS-1:0] half);
      wait_for_medians();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= half;
      @(posedge clock);
      csr_write_en <= 1'b0;
      half_writes++;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset half-width of one: extremes, ties, and restarts of a partial window.
      foreach (directed_values[i]) begin
         send_sample(directed_values[i], directed_starts[i]);
      end
      write_half(4'd0);
      send_sample(16'h0000, 1'b0);
      send_sample(16'hFFFF, 1'b1);
      send_sample(16'hAAAA, 1'b0);
      send_sample(16'h5555, 1'b0);

      for (int seg = 0; seg < SEGMENT_COUNT; seg++) begin
         if (seg < 4) begin
            req_idle_pct = 19;
            rsp_stall_pct = 67;
         end else if (seg < 7) begin
            req_idle_pct = 67;
            rsp_stall_pct = 19;
         end else begin
            req_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         write_half(segment_halves[seg]);
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            if (n == SEGMENT_ITEMS / 2) begin
               wait_for_medians();
            end
            send_sample(random_sample(), $urandom_range(99) < 3);
         end
      end

      wait_for_medians();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d requests and checked %0d medians over %0d half-width writes,",
               requests_sent, medians_checked, half_writes);
      $display("covering widths 0 to 15, ties, restarts and stalls on both channels.");
      if (failures == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire
